### rtl/fvn_pkg.sv
`timescale 1ns / 1ps
package fvn_pkg;

   // Default build-time limit on summed octaves
   localparam int MAX_OCTAVES_DEF = 8;

   // Field widths
   localparam int COORD_W = 24;
   localparam int FREQ_W  = 24;
   localparam int OCT_W   = 4;
   localparam int SEED_W  = 8;
   localparam int NOISE_W = 16;
   localparam int POS_W   = 32;  // scaled position: 8 index bits, 24 fraction bits
   localparam int FRAC_W  = 16;
   localparam int CORNER_W = 24; // corner or blend value, Q8.16

   // Register indexes
   localparam logic [1:0] CSR_FREQUENCY = 2'd0;
   localparam logic [1:0] CSR_OCTAVES   = 2'd1;
   localparam logic [1:0] CSR_SEED      = 2'd2;

   // Reset values
   localparam logic [FREQ_W-1:0] FREQ_RESET   = 24'd65536;
   localparam logic [OCT_W-1:0]  OCT_RESET    = 4'd4;
   localparam logic [SEED_W-1:0] SEED_RESET   = 8'd20;

   // Smoothstep constant, 3.0 in Q2.16
   localparam logic [17:0] THREE_Q16 = 18'd196608;

   // Lattice hash table
   localparam logic [7:0] PERM_TAB [256] = '{
      8'd208,8'd34,8'd231,8'd213,8'd32,8'd248,8'd233,8'd56,8'd161,8'd78,8'd24,8'd140,
      8'd71,8'd48,8'd140,8'd254,8'd245,8'd255,8'd247,8'd247,8'd40,8'd185,8'd248,8'd251,
      8'd245,8'd28,8'd124,8'd204,8'd204,8'd76,8'd36,8'd1,8'd107,8'd28,8'd234,8'd163,
      8'd202,8'd224,8'd245,8'd128,8'd167,8'd204,8'd9,8'd92,8'd217,8'd54,8'd239,8'd174,
      8'd173,8'd102,8'd193,8'd189,8'd190,8'd121,8'd100,8'd108,8'd167,8'd44,8'd43,8'd77,
      8'd180,8'd204,8'd8,8'd81,8'd70,8'd223,8'd11,8'd38,8'd24,8'd254,8'd210,8'd210,
      8'd177,8'd32,8'd81,8'd195,8'd243,8'd125,8'd8,8'd169,8'd112,8'd32,8'd97,8'd53,
      8'd195,8'd13,8'd203,8'd9,8'd47,8'd104,8'd125,8'd117,8'd114,8'd124,8'd165,8'd203,
      8'd181,8'd235,8'd193,8'd206,8'd70,8'd180,8'd174,8'd0,8'd167,8'd181,8'd41,8'd164,
      8'd30,8'd116,8'd127,8'd198,8'd245,8'd146,8'd87,8'd224,8'd149,8'd206,8'd57,8'd4,
      8'd192,8'd210,8'd65,8'd210,8'd129,8'd240,8'd178,8'd105,8'd228,8'd108,8'd245,8'd148,
      8'd140,8'd40,8'd35,8'd195,8'd38,8'd58,8'd65,8'd207,8'd215,8'd253,8'd65,8'd85,
      8'd208,8'd76,8'd62,8'd3,8'd237,8'd55,8'd89,8'd232,8'd50,8'd217,8'd64,8'd244,
      8'd157,8'd199,8'd121,8'd252,8'd90,8'd17,8'd212,8'd203,8'd149,8'd152,8'd140,8'd187,
      8'd234,8'd177,8'd73,8'd174,8'd193,8'd100,8'd192,8'd143,8'd97,8'd53,8'd145,8'd135,
      8'd19,8'd103,8'd13,8'd90,8'd135,8'd151,8'd199,8'd91,8'd239,8'd247,8'd33,8'd39,
      8'd145,8'd101,8'd120,8'd99,8'd3,8'd186,8'd86,8'd99,8'd41,8'd237,8'd203,8'd111,
      8'd79,8'd220,8'd135,8'd158,8'd42,8'd30,8'd154,8'd120,8'd67,8'd87,8'd167,8'd135,
      8'd176,8'd183,8'd191,8'd253,8'd115,8'd184,8'd21,8'd233,8'd58,8'd129,8'd233,8'd142,
      8'd39,8'd128,8'd211,8'd118,8'd137,8'd139,8'd255,8'd114,8'd20,8'd218,8'd113,8'd154,
      8'd27,8'd127,8'd246,8'd250,8'd1,8'd8,8'd198,8'd250,8'd209,8'd92,8'd222,8'd173,
      8'd21,8'd88,8'd102,8'd219
   };

endpackage

### rtl/fvn_octave_cell.sv
`timescale 1ns / 1ps
module fvn_octave_cell
   import fvn_pkg::*;
#(
   parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
   parameter int IDX         = 0,
   parameter int ACC_W       = 24 + MAX_OCTAVES,
   parameter int NW          = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic [NW-1:0]       n_eff,
   input  logic [SEED_W-1:0]   seed,
   input  logic                in_valid,
   input  logic [POS_W-1:0]    in_px,
   input  logic [POS_W-1:0]    in_py,
   input  logic [ACC_W-1:0]    in_acc,
   output logic                out_valid,
   output logic [POS_W-1:0]    out_px,
   output logic [POS_W-1:0]    out_py,
   output logic [ACC_W-1:0]    out_acc
);

   localparam logic [NW-1:0] IDX_N = NW'(IDX);

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [POS_W-1:0]    px1_ff, py1_ff, px2_ff, py2_ff, px3_ff, py3_ff;
   logic [POS_W-1:0]    px4_ff, py4_ff, px5_ff, py5_ff;
   logic [ACC_W-1:0]    acc1_ff, acc2_ff, acc3_ff, acc4_ff, acc5_ff;

   // stage 1 payload
   logic [7:0]          xi1_ff, mid0_1_ff, mid1_1_ff;
   logic [FRAC_W-1:0]   fx1_ff, fy1_ff, s2x1_ff, s2y1_ff;
   // stage 2 payload
   logic [7:0]          c00_2_ff, c10_2_ff, c01_2_ff, c11_2_ff;
   logic [FRAC_W-1:0]   wx2_ff, wy2_ff;
   // stage 3 payload
   logic [CORNER_W-1:0] lo3_ff, hi3_ff;
   logic [FRAC_W-1:0]   wy3_ff;
   // stage 4 payload
   logic [CORNER_W-1:0] noise4_ff;

   logic [7:0]          xi_in, yi_in, mid0_in, mid1_in;
   logic [FRAC_W-1:0]   fx_in, fy_in, s2x_in, s2y_in;
   logic [31:0]         sqx, sqy;
   logic [7:0]          xi_p1;
   logic [33:0]         prx, pry;
   logic [CORNER_W-1:0] lo_in, hi_in, noise_in;
   logic [23:0]         dlo, dhi;
   logic [39:0]         dn;
   logic [CORNER_W-1:0] dd;
   logic                active;
   logic [ACC_W-1:0]    acc_in;

   // stage 1: lattice row hash and fraction squares
   always_comb begin
      xi_in   = in_px[31:24];
      yi_in   = in_py[31:24];
      fx_in   = in_px[23:8];
      fy_in   = in_py[23:8];
      mid0_in = PERM_TAB[yi_in + seed];
      mid1_in = PERM_TAB[yi_in + seed + 8'd1];
      sqx     = fx_in * fx_in;
      sqy     = fy_in * fy_in;
      s2x_in  = sqx[31:16];
      s2y_in  = sqy[31:16];
   end

   // stage 2: corner hash and smoothstep weights
   always_comb begin
      xi_p1 = xi1_ff + 8'd1;
      prx   = s2x1_ff * (THREE_Q16 - {1'b0, fx1_ff, 1'b0});
      pry   = s2y1_ff * (THREE_Q16 - {1'b0, fy1_ff, 1'b0});
   end

   // stage 3: blend along x
   always_comb begin
      if (c10_2_ff >= c00_2_ff) begin
         dlo   = (c10_2_ff - c00_2_ff) * wx2_ff;
         lo_in = {c00_2_ff, 16'd0} + dlo;
      end else begin
         dlo   = (c00_2_ff - c10_2_ff) * wx2_ff;
         lo_in = {c00_2_ff, 16'd0} - dlo;
      end
      if (c11_2_ff >= c01_2_ff) begin
         dhi   = (c11_2_ff - c01_2_ff) * wx2_ff;
         hi_in = {c01_2_ff, 16'd0} + dhi;
      end else begin
         dhi   = (c01_2_ff - c11_2_ff) * wx2_ff;
         hi_in = {c01_2_ff, 16'd0} - dhi;
      end
   end

   // stage 4: blend along y
   always_comb begin
      if (hi3_ff >= lo3_ff) begin
         dn       = (hi3_ff - lo3_ff) * wy3_ff;
         dd       = dn[39:16];
         noise_in = lo3_ff + dd;
      end else begin
         dn       = (lo3_ff - hi3_ff) * wy3_ff;
         dd       = dn[39:16];
         noise_in = lo3_ff - dd;
      end
   end

   // stage 5: Horner accumulate, earlier octaves get doubled
   always_comb begin
      active = (IDX_N < n_eff);
      acc_in = active ? ((acc4_ff << 1) + ACC_W'(noise4_ff)) : acc4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px1_ff    <= in_px;
         py1_ff    <= in_py;
         acc1_ff   <= in_acc;
         xi1_ff    <= xi_in;
         mid0_1_ff <= mid0_in;
         mid1_1_ff <= mid1_in;
         fx1_ff    <= fx_in;
         fy1_ff    <= fy_in;
         s2x1_ff   <= s2x_in;
         s2y1_ff   <= s2y_in;

         px2_ff    <= px1_ff;
         py2_ff    <= py1_ff;
         acc2_ff   <= acc1_ff;
         c00_2_ff  <= PERM_TAB[mid0_1_ff + xi1_ff];
         c10_2_ff  <= PERM_TAB[mid0_1_ff + xi_p1];
         c01_2_ff  <= PERM_TAB[mid1_1_ff + xi1_ff];
         c11_2_ff  <= PERM_TAB[mid1_1_ff + xi_p1];
         wx2_ff    <= prx[31:16];
         wy2_ff    <= pry[31:16];

         px3_ff    <= px2_ff;
         py3_ff    <= py2_ff;
         acc3_ff   <= acc2_ff;
         lo3_ff    <= lo_in;
         hi3_ff    <= hi_in;
         wy3_ff    <= wy2_ff;

         px4_ff    <= px3_ff;
         py4_ff    <= py3_ff;
         acc4_ff   <= acc3_ff;
         noise4_ff <= noise_in;

         px5_ff    <= px4_ff;
         py5_ff    <= py4_ff;
         acc5_ff   <= acc_in;
      end
   end

   // next octave sees the position doubled
   assign out_valid = v5_ff;
   assign out_px    = {px5_ff[POS_W-2:0], 1'b0};
   assign out_py    = {py5_ff[POS_W-2:0], 1'b0};
   assign out_acc   = acc5_ff;

endmodule

### rtl/fvn_div_cell.sv
`timescale 1ns / 1ps
module fvn_div_cell
   import fvn_pkg::*;
#(
   parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [MAX_OCTAVES-1:0] divisor,
   input  logic                   in_valid,
   input  logic [MAX_OCTAVES-1:0] in_rem,
   input  logic [NOISE_W-1:0]     in_low,
   output logic                   out_valid,
   output logic [MAX_OCTAVES-1:0] out_rem,
   output logic [NOISE_W-1:0]     out_low
);

   logic                   v_ff;
   logic [MAX_OCTAVES-1:0] rem_ff, rem_in;
   logic [NOISE_W-1:0]     low_ff, low_in;
   logic [MAX_OCTAVES:0]   trial, diff;
   logic                   ge;

   // one restoring step: next dividend bit in, quotient bit out
   always_comb begin
      trial  = {in_rem, in_low[NOISE_W-1]};
      diff   = trial - {1'b0, divisor};
      ge     = (trial >= {1'b0, divisor});
      rem_in = ge ? diff[MAX_OCTAVES-1:0] : trial[MAX_OCTAVES-1:0];
      low_in = {in_low[NOISE_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
      end
   end

   assign out_valid = v_ff;
   assign out_rem   = rem_ff;
   assign out_low   = low_ff;

endmodule

### rtl/fractal_value_noise_2d.sv
`timescale 1ns / 1ps
// Fractal value noise: takes one (x, y) beat per cycle while not stalled and returns one
// Q0.16 noise beat per input, in order. The path is a registered frequency multiply, a
// chain of MAX_OCTAVES octave cells of five stages each (hash, smoothstep, x blend,
// y blend, accumulate), and a 16-stage divider chain that normalizes by the weight
// total, one quotient bit per stage. Octaves beyond the programmed count pass through
// unchanged. The whole chain stalls while a result waits on rsp_tready. Registers must be
// written through the csr port only while idle; the block itself does not enforce it.
module fractal_value_noise_2d
   import fvn_pkg::*;
#(
   parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [2*COORD_W-1:0]   req_tdata,   // x_coord[23:0], y_coord[47:24]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [NOISE_W-1:0]     rsp_tdata,   // noise_value[15:0]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [FREQ_W-1:0]      csr_data
);

   localparam int ACC_W = 24 + MAX_OCTAVES;
   localparam int NW    = $clog2(MAX_OCTAVES + 1);

   logic [FREQ_W-1:0] freq_ff;
   logic [OCT_W-1:0]  oct_ff;
   logic [SEED_W-1:0] seed_ff;
   logic              en;
   logic [NW-1:0]     n_eff;
   logic [MAX_OCTAVES:0]   pow2;
   logic [MAX_OCTAVES-1:0] divisor;
   logic [47:0]       mx, my;
   logic              v0_ff;
   logic [POS_W-1:0]  px0_ff, py0_ff;

   logic                   cv [MAX_OCTAVES+1];
   logic [POS_W-1:0]       cpx [MAX_OCTAVES+1];
   logic [POS_W-1:0]       cpy [MAX_OCTAVES+1];
   logic [ACC_W-1:0]       cacc [MAX_OCTAVES+1];
   logic                   dv [NOISE_W+1];
   logic [MAX_OCTAVES-1:0] drem [NOISE_W+1];
   logic [NOISE_W-1:0]     dlow [NOISE_W+1];

   // whole pipeline advances unless the result beat is held
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_RESET;
         oct_ff  <= OCT_RESET;
         seed_ff <= SEED_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FREQUENCY: freq_ff <= csr_data;
            CSR_OCTAVES:   oct_ff  <= csr_data[OCT_W-1:0];
            CSR_SEED:      seed_ff <= csr_data[SEED_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp octave count, divisor is 2^n - 1
   always_comb begin
      if (32'(oct_ff) > 32'(MAX_OCTAVES)) begin
         n_eff = NW'(MAX_OCTAVES);
      end else if (oct_ff == '0) begin
         n_eff = NW'(1);
      end else begin
         n_eff = NW'(oct_ff);
      end
      pow2    = (MAX_OCTAVES+1)'(1) << n_eff;
      divisor = MAX_OCTAVES'(pow2 - (MAX_OCTAVES+1)'(1));
   end

   // frequency scaling, low 32 bits kept
   assign mx = req_tdata[COORD_W-1:0] * freq_ff;
   assign my = req_tdata[2*COORD_W-1:COORD_W] * freq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px0_ff <= mx[POS_W-1:0];
         py0_ff <= my[POS_W-1:0];
      end
   end

   assign cv[0]   = v0_ff;
   assign cpx[0]  = px0_ff;
   assign cpy[0]  = py0_ff;
   assign cacc[0] = '0;

   // octave chain
   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
      fvn_octave_cell #(
         .MAX_OCTAVES(MAX_OCTAVES),
         .IDX        (k),
         .ACC_W      (ACC_W),
         .NW         (NW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .n_eff    (n_eff),
         .seed     (seed_ff),
         .in_valid (cv[k]),
         .in_px    (cpx[k]),
         .in_py    (cpy[k]),
         .in_acc   (cacc[k]),
         .out_valid(cv[k+1]),
         .out_px   (cpx[k+1]),
         .out_py   (cpy[k+1]),
         .out_acc  (cacc[k+1])
      );
   end

   // divide by 256: drop low byte; high bits seed the remainder
   assign dv[0]   = cv[MAX_OCTAVES];
   assign drem[0] = cacc[MAX_OCTAVES][ACC_W-1:24];
   assign dlow[0] = cacc[MAX_OCTAVES][23:8];

   for (genvar j = 0; j < NOISE_W; j++) begin : g_div
      fvn_div_cell #(
         .MAX_OCTAVES(MAX_OCTAVES)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .divisor  (divisor),
         .in_valid (dv[j]),
         .in_rem   (drem[j]),
         .in_low   (dlow[j]),
         .out_valid(dv[j+1]),
         .out_rem  (drem[j+1]),
         .out_low  (dlow[j+1])
      );
   end

   assign rsp_tvalid = dv[NOISE_W];
   assign rsp_tdata  = dlow[NOISE_W];

endmodule

### test/tb_fractal_value_noise_2d.sv
`timescale 1ns / 1ps
module tb_fractal_value_noise_2d;
   import fvn_pkg::*;

   localparam int LATENCY = 1 + 5*MAX_OCTAVES_DEF + 16;
   localparam int CYCLE_LIMIT = 400000;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [2*COORD_W-1:0] req_tdata;   // x_coord[23:0], y_coord[47:24]
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [NOISE_W-1:0]   rsp_tdata;   // noise_value[15:0]
   logic                 csr_valid;
   logic                 csr_ready;
   logic [1:0]           csr_index;
   logic [FREQ_W-1:0]    csr_data;

   fractal_value_noise_2d DUT (.*);

   // predictor copy of the registers
   logic [FREQ_W-1:0] cur_freq;
   logic [OCT_W-1:0]  cur_oct;
   logic [SEED_W-1:0] cur_seed;

   logic [NOISE_W-1:0] noise_q[$];
   int   mismatches;
   int   checked;
   int   cycles;
   bit   idle_off;
   bit   hold_rsp;
   bit   timed_out;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // lattice corner value, Q8.16
   function automatic longint unsigned lattice_val(int unsigned col, int unsigned row);
      int unsigned mid;
      mid = 32'(PERM_TAB[(row + cur_seed) & 255]);
      return longint'(PERM_TAB[(mid + col) & 255]) << 16;
   endfunction

   function automatic longint unsigned fade(longint unsigned s);
      longint unsigned s2;
      s2 = (s * s) >> 16;
      return (s2 * (196608 - 2 * s)) >> 16;
   endfunction

   function automatic longint unsigned mix(longint unsigned a, longint unsigned b,
                                           longint unsigned w);
      if (b >= a) return a + (((b - a) * w) >> 16);
      return a - (((a - b) * w) >> 16);
   endfunction

   function automatic logic [NOISE_W-1:0] fractal_noise(logic [COORD_W-1:0] xc,
                                                        logic [COORD_W-1:0] yc);
      longint unsigned px, py, sum, total, wx, wy, lo, hi;
      int unsigned n, xi, yi;
      px = (longint'(xc) * cur_freq) & 64'hFFFF_FFFF;
      py = (longint'(yc) * cur_freq) & 64'hFFFF_FFFF;
      n = 32'(cur_oct);
      if (n < 1) n = 1;
      if (n > MAX_OCTAVES_DEF) n = MAX_OCTAVES_DEF;
      sum = 0;
      for (int i = 0; i < n; i++) begin
         xi = 32'((px >> 24) & 255);
         yi = 32'((py >> 24) & 255);
         wx = fade((px >> 8) & 16'hFFFF);
         wy = fade((py >> 8) & 16'hFFFF);
         lo = mix(lattice_val(xi, yi), lattice_val(xi + 1, yi), wx);
         hi = mix(lattice_val(xi, yi + 1), lattice_val(xi + 1, yi + 1), wx);
         sum += mix(lo, hi, wy) << (n - 1 - i);
         px = (px << 1) & 64'hFFFF_FFFF;
         py = (py << 1) & 64'hFFFF_FFFF;
      end
      total = 256 * ((64'd1 << n) - 1);
      return NOISE_W'(sum / total);
   endfunction

   // valid drops only for an idle burst
   task automatic random_gap();
      if (!idle_off && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // send one coordinate beat, predicting at acceptance
   task automatic send_point(logic [COORD_W-1:0] xc, logic [COORD_W-1:0] yc);
      random_gap();
      req_tvalid <= 1'b1;
      req_tdata  <= {yc, xc};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      noise_q = {noise_q, fractal_noise(xc, yc)};
   endtask

   task automatic write_reg(logic [1:0] idx, logic [FREQ_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FREQUENCY: cur_freq = val;
         CSR_OCTAVES:   cur_oct  = val[OCT_W-1:0];
         CSR_SEED:      cur_seed = val[SEED_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (noise_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_all(logic [FREQ_W-1:0] f, logic [OCT_W-1:0] o, logic [SEED_W-1:0] s);
      drain();
      write_reg(CSR_FREQUENCY, f);
      write_reg(CSR_OCTAVES, FREQ_W'(o));
      write_reg(CSR_SEED, FREQ_W'(s));
      csr_valid <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (noise_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected noise beat %0d", rsp_tdata);
         end else begin
            logic [NOISE_W-1:0] exp_v;
            exp_v = noise_q.pop_front();
            checked++;
            if (rsp_tdata !== exp_v) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("noise mismatch: expected %0d got %0d", exp_v, rsp_tdata);
            end
         end
      end
   end

   // receiver stalls
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) rsp_tready <= 1'b0;
         else if (!idle_off && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(posedge clock);
         end else rsp_tready <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("FAIL");
         $finish;
      end
   end

   task automatic test_defaults();
      send_point('0, '0);
      send_point('1, '1);
      send_point(24'h000080, 24'h0000C0);
      send_point(24'hFF_FF80, 24'h0001_00);
      send_point(24'h00_0100, 24'hFF_FFFF);
   endtask

   task automatic test_octave_edges();
      set_all(24'd65536, 4'd0, 8'd0);          // zero count acts as one
      send_point(24'h000140, 24'h000260);
      send_point('1, '0);
      set_all(24'hFFFFFF, 4'd15, 8'd255);      // count saturates, max freq and seed
      send_point(24'h123456, 24'h654321);
      send_point('1, '1);
      set_all(24'd65536, 4'd8, 8'd1);
      send_point(24'h00FF80, 24'h00FF40);      // lattice wrap at index 255
      send_point(24'h000001, 24'h000001);
   endtask

   task automatic test_zero_freq();
      set_all(24'd0, 4'd3, 8'd77);
      send_point('1, 24'h5A5A5A);
      send_point(24'h0, 24'h1);
   endtask

   task automatic test_long_stall();
      set_all(24'd131072, 4'd2, 8'd9);
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 100; i++)
            send_point(COORD_W'($urandom), COORD_W'($urandom));
      join
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 6; ph++) begin
         set_all(($urandom_range(0, 3) == 0) ? FREQ_W'($urandom)
                                             : FREQ_W'($urandom_range(0, 262144)),
                 OCT_W'($urandom_range(0, 15)), SEED_W'($urandom));
         if (ph == 5) idle_off = 1'b1;
         for (int i = 0; i < 125; i++)
            send_point(COORD_W'($urandom), COORD_W'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FREQUENCY;
      csr_data = '0;
      cur_freq = FREQ_RESET;
      cur_oct = OCT_RESET;
      cur_seed = SEED_RESET;
      mismatches = 0;
      checked = 0;
      cycles = 0;
      idle_off = 1'b0;
      hold_rsp = 1'b0;
      timed_out = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_octave_edges();
      test_zero_freq();
      test_long_stall();
      test_random();
      drain();
      $display("Checked %0d noise samples over octave, seed, frequency extremes and stalls.",
               checked);
      if (mismatches == 0 && noise_q.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

### fractal_value_noise_2d.f
rtl/fvn_pkg.sv
rtl/fvn_octave_cell.sv
rtl/fvn_div_cell.sv
rtl/fractal_value_noise_2d.sv
test/tb_fractal_value_noise_2d.sv
